/* rtl/core/csfb_pkg.sv */
// Package with the frame constants, record types and CRC helper for the frame builder.
package csfb_pkg;

   localparam logic [7:0]  FRAME_SYNC   = 8'hD3;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam int          CRC_SPAN     = 15;
   localparam int          FRAME_BYTES  = 17;
   localparam int          POS_W        = 5;
   localparam int          CSR_INDEX_W  = 2;
   localparam int          CSR_DATA_W   = 16;
   localparam int          QUEUE_DEPTH_DEF = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_VERSION = 2'd0,
      CSR_FRAME_KIND    = 2'd1,
      CSR_SOURCE_NODE   = 2'd2,
      CSR_DEST_NODE     = 2'd3
   } csr_index_type;

   // The first fifteen frame bytes, byte zero in the most significant bits.
   typedef struct packed {
      logic [7:0]  sync;
      logic [7:0]  flags;
      logic [15:0] seq;
      logic [15:0] src;
      logic [15:0] dst;
      logic [31:0] payload;
      logic [23:0] stamp;
   } frame_head_type;

   localparam int HEAD_W = $bits(frame_head_type);

   function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] crc;
      crc = acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

/* rtl/core/csfb_req_if.sv */
// Request channel interface carrying the timestamp and payload of one frame request.
interface csfb_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] time_offset_us;
   logic [31:0] app_payload;

   modport source (output valid, output time_offset_us, output app_payload, input ready);
   modport sink   (input valid, input time_offset_us, input app_payload, output ready);
endinterface

/* rtl/core/csfb_rsp_if.sv */
// Result channel interface carrying one serialized frame byte and its last-byte flag.
interface csfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* rtl/core/csfb_queue.sv */
// Small queue of frame headers between the request front end and the serializer.
module csfb_queue
   import csfb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  frame_head_type push_rec,
   output logic           pop_valid,
   input  logic           pop_ready,
   output frame_head_type pop_rec
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   frame_head_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* rtl/core/csfb_front.sv */
// Front end that holds the configuration and sequence counter and assembles frame headers.
module csfb_front
   import csfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   csfb_req_if.sink               req_chan,
   output logic                   push_valid,
   input  logic                   push_ready,
   output frame_head_type         push_rec
);

   logic [3:0]  version_ff, version_in;
   logic [3:0]  kind_ff, kind_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [15:0] seq_ff, seq_in;
   logic        accept;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid & push_ready;

   always_comb begin
      push_rec.sync    = FRAME_SYNC;
      push_rec.flags   = {version_ff, kind_ff};
      push_rec.seq     = seq_ff;
      push_rec.src     = src_ff;
      push_rec.dst     = dst_ff;
      push_rec.payload = req_chan.app_payload;
      push_rec.stamp   = req_chan.time_offset_us;
   end

   always_comb begin
      version_in = version_ff;
      kind_in    = kind_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      seq_in     = accept ? seq_ff + 16'd1 : seq_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_VERSION: version_in = csr_wr_data[3:0];
            CSR_FRAME_KIND:    kind_in    = csr_wr_data[3:0];
            CSR_SOURCE_NODE:   src_in     = csr_wr_data;
            CSR_DEST_NODE:     dst_in     = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 4'd1;
         kind_ff    <= 4'd0;
         src_ff     <= 16'd1;
         dst_ff     <= 16'hFFFF;
         seq_ff     <= '0;
      end else begin
         version_ff <= version_in;
         kind_ff    <= kind_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         seq_ff     <= seq_in;
      end
   end

endmodule

/* rtl/core/csfb_back.sv */
// Back end that serializes a frame header byte by byte and appends the running CRC.
module csfb_back
   import csfb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  frame_head_type pop_rec,
   csfb_rsp_if.source     rsp_chan
);

   localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(CRC_SPAN);
   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

   logic [HEAD_W-1:0] head_ff, head_in;
   logic [15:0]       crc_ff, crc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              active_ff, active_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              adv;
   logic              load;
   logic [7:0]        cur_byte;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_byte = rsp_byte_ff;
   assign rsp_chan.last_byte  = rsp_last_ff;

   assign adv       = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = !active_ff || (adv && (pos_ff == POS_LAST));
   assign load      = pop_valid && pop_ready;

   always_comb begin
      priority if (pos_ff < POS_CRC_HI) begin
         cur_byte = head_ff[HEAD_W-1 -: 8];
      end else if (pos_ff == POS_CRC_HI) begin
         cur_byte = crc_ff[15:8];
      end else begin
         cur_byte = crc_ff[7:0];
      end
   end

   always_comb begin
      head_in      = head_ff;
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (active_ff && adv) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = (pos_ff == POS_LAST);
         pos_in       = pos_ff + 1'b1;
         if (pos_ff < POS_CRC_HI) begin
            crc_in  = crc_feed(crc_ff, cur_byte);
            head_in = {head_ff[HEAD_W-9:0], 8'h00};
         end
         if (pos_ff == POS_LAST) begin
            active_in = 1'b0;
         end
      end else if (adv) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         head_in   = pop_rec;
         crc_in    = CRC_INIT;
         pos_in    = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      crc_ff      <= crc_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

/* rtl/core/crc_sealed_frame_builder.sv */
// Top level of the CRC-sealed frame builder: front end, header queue and serializer.
//
// Each request on req_chan carries a 24-bit timestamp and a 32-bit payload and
// produces one 17-byte frame on rsp_chan, one byte per transfer, byte zero first,
// with last_byte set on the CRC low byte. The frame carries sync, flags, the
// sequence number, source and destination IDs, payload, timestamp and a
// CRC-16 (polynomial 0x1021, initial value 0xFFFF) over the first 15 bytes.
// The csr_ port writes the version, kind, source and destination registers;
// write it only while no frame is pending.
// A request is accepted when the header queue has room; its header is written
// into the queue, then loaded into the serializer, and its first byte is then
// registered onto rsp_chan. The serializer sends one byte per cycle while rsp_chan
// is ready, with frames following back to back; the queue takes up to QUEUE_DEPTH
// requests ahead of the frame on the wire. When rsp_chan stalls, the current byte holds and the serializer waits;
// requests are refused once the queue is full.
// Reset clears the sequence counter, the queue and the output and restores
// the register defaults.
module crc_sealed_frame_builder
   import csfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   csfb_req_if.sink               req_chan,
   csfb_rsp_if.source             rsp_chan
);

   logic           push_valid, push_ready;
   logic           pop_valid, pop_ready;
   frame_head_type push_rec, pop_rec;

   csfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_rec    (push_rec)
   );

   csfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   csfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_rec   (pop_rec),
      .rsp_chan  (rsp_chan)
   );

endmodule

/* dv/crc_sealed_frame_builder_tb.sv */
// Self-checking testbench for the CRC-sealed frame builder with a built-in frame predictor.
module crc_sealed_frame_builder_tb;
   import csfb_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTED = 40;
   localparam int RUN_LIMIT = 2000000;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } wire_byte_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_FRAME_VERSION;
   logic [15:0]   csr_wr_data = '0;

   csfb_req_if req_chan ();
   csfb_rsp_if rsp_chan ();

   crc_sealed_frame_builder i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Shadow copy of the block's registers and sequence counter.
   logic [3:0]    cfg_version = 4'd1;
   logic [3:0]    cfg_kind = 4'd0;
   logic [15:0]   cfg_source = 16'd1;
   logic [15:0]   cfg_dest = 16'hFFFF;
   logic [15:0]   seq_count = '0;

   wire_byte_type expected_frame_bytes[$];

   int  error_count = 0;
   int  bytes_checked = 0;
   int  frames_requested = 0;
   int  csr_writes = 0;
   int  rsp_hold_cycles = 0;
   bit  req_throttle = 1'b1;
   bit  rsp_throttle = 1'b1;

   always #2 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.time_offset_us = '0;
      req_chan.app_payload = '0;
      rsp_chan.ready = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("MISMATCH after %0d bytes: %s", bytes_checked, msg);
      end
      error_count++;
   endtask

   function automatic logic [31:0] rand_field(input int bits);
      logic [31:0] mask;
      mask = 32'hFFFF_FFFF >> (32 - bits);
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return mask;
         end
         default: begin
            return $urandom() & mask;
         end
      endcase
   endfunction

   // Builds the 17 bytes of the frame for one accepted request and queues them.
   task automatic predict_frame(input logic [23:0] stamp, input logic [31:0] payload);
      frame_head_type head;
      logic [15:0]    crc;
      logic           feedback;
      wire_byte_type  entry;
      head.sync = FRAME_SYNC;
      head.flags = {cfg_version, cfg_kind};
      head.seq = seq_count;
      head.src = cfg_source;
      head.dst = cfg_dest;
      head.payload = payload;
      head.stamp = stamp;
      crc = CRC_INIT;
      for (int b = HEAD_W - 1; b >= 0; b--) begin
         feedback = crc[15] ^ head[b];
         crc = {crc[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      end
      for (int i = 0; i < CRC_SPAN; i++) begin
         entry.frame_byte = head[HEAD_W - 1 - 8 * i -: 8];
         entry.last_byte = 1'b0;
         expected_frame_bytes.insert(expected_frame_bytes.size(), entry);
      end
      entry.frame_byte = crc[15:8];
      entry.last_byte = 1'b0;
      expected_frame_bytes.insert(expected_frame_bytes.size(), entry);
      entry.frame_byte = crc[7:0];
      entry.last_byte = 1'b1;
      expected_frame_bytes.insert(expected_frame_bytes.size(), entry);
      seq_count = seq_count + 16'd1;
      frames_requested++;
   endtask

   task automatic send_request(input logic [23:0] stamp, input logic [31:0] payload);
      int gap;
      gap = req_throttle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.time_offset_us <= stamp;
      req_chan.app_payload <= payload;
      do @(posedge clock); while (!req_chan.ready);
      predict_frame(stamp, payload);
   endtask

   task automatic wait_frames_done();
      req_chan.valid <= 1'b0;
      while (expected_frame_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FRAME_VERSION: begin
            cfg_version = data[3:0];
         end
         CSR_FRAME_KIND: begin
            cfg_kind = data[3:0];
         end
         CSR_SOURCE_NODE: begin
            cfg_source = data;
         end
         CSR_DEST_NODE: begin
            cfg_dest = data;
         end
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic write_all_registers(input logic [15:0] version, input logic [15:0] kind,
                                      input logic [15:0] source, input logic [15:0] dest);
      write_register(CSR_FRAME_VERSION, version);
      write_register(CSR_FRAME_KIND, kind);
      write_register(CSR_SOURCE_NODE, source);
      write_register(CSR_DEST_NODE, dest);
   endtask

   task automatic test_reset_defaults();
      send_request(24'h000000, 32'h0000_0000);
      send_request(24'hFFFFFF, 32'hFFFF_FFFF);
      send_request(24'hAAAAAA, 32'h5555_5555);
      send_request(24'h555555, 32'hAAAA_AAAA);
      wait_frames_done();
   endtask

   task automatic test_register_extremes();
      write_all_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(24'h123456, 32'h89AB_CDEF);
      send_request(24'hFFFFFF, 32'h0000_0000);
      wait_frames_done();
      write_all_registers(16'h000F, 16'h000F, 16'hFFFF, 16'hFFFF);
      send_request(24'h000000, 32'hFFFF_FFFF);
      send_request(24'h800001, 32'h8000_0001);
      wait_frames_done();
      // Upper bits of the nibble registers are dropped by the block.
      write_all_registers(16'hFFF7, 16'h0AB9, 16'h8001, 16'h7FFE);
      send_request(24'h0F0F0F, 32'hF0F0_F0F0);
      send_request(24'hC3C3C3, 32'h3C3C_3C3C);
      wait_frames_done();
   endtask

   task automatic test_backpressure();
      req_throttle = 1'b0;
      rsp_throttle = 1'b0;
      rsp_hold_cycles = 300;
      repeat (8) send_request(24'(rand_field(24)), rand_field(32));
      wait_frames_done();
      req_throttle = 1'b1;
      rsp_throttle = 1'b1;
   endtask

   task automatic test_random_frames();
      for (int phase = 0; phase < 4; phase++) begin
         write_all_registers(16'($urandom()), 16'($urandom()),
                             16'(rand_field(16)), 16'(rand_field(16)));
         req_throttle = (phase == 0) || (phase == 2);
         rsp_throttle = (phase == 0) || (phase == 3);
         repeat (20) send_request(24'(rand_field(24)), rand_field(32));
         wait_frames_done();
      end
      req_throttle = 1'b1;
      rsp_throttle = 1'b1;
   endtask

   initial begin
      while (reset) @(posedge clock);
      forever begin
         int stall;
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_throttle ? $urandom_range(0, 13) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_frame_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_chan.frame_byte));
         end else begin
            want = expected_frame_bytes.pop_front();
            if (rsp_chan.frame_byte !== want.frame_byte) begin
               report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                         rsp_chan.frame_byte, want.frame_byte));
            end
            if (rsp_chan.last_byte !== want.last_byte) begin
               report_mismatch($sformatf("last_byte %0b, expected %0b",
                                         rsp_chan.last_byte, want.last_byte));
            end
         end
         bytes_checked++;
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("Run timed out with %0d bytes still expected.", expected_frame_bytes.size());
      $display("crc_sealed_frame_builder regression: fail");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_backpressure();
      test_random_frames();
      $display("Checked %0d frames (%0d bytes) over %0d register writes.",
               frames_requested, bytes_checked, csr_writes);
      $display("Covered field extremes, nibble truncation, a long output stall and idle gaps.");
      if (error_count == 0 && expected_frame_bytes.size() == 0) begin
         $display("crc_sealed_frame_builder regression: pass");
      end else begin
         $display("crc_sealed_frame_builder regression: fail");
      end
      $finish;
   end

endmodule
